### hw/rtl/utsd_pkg.sv
// Shared types and constants for the UTF-16 stream decoder.
package utsd_pkg;

    localparam int UnitW = 16;
    localparam int CpW   = 21;
    localparam int HighW = 10;

    localparam logic [CpW-1:0]   ReplCp     = 21'h00FFFD;
    localparam logic [CpW-1:0]   SuppBase   = 21'h010000;
    localparam logic [UnitW-1:0] BmpLastLo  = 16'hD7FF;
    localparam logic [UnitW-1:0] BmpFirstHi = 16'hE000;
    localparam logic [UnitW-1:0] NonChar    = 16'hFFFE;
    localparam logic [5:0]       HighTag    = 6'b110110;  // D800..DBFF
    localparam logic [5:0]       LowTag     = 6'b110111;  // DC00..DFFF
    localparam logic [4:0]       MaxPlane   = 5'h10;

    typedef struct packed {
        logic [UnitW-1:0] code_unit;
        logic             half_unit;
        logic             end_of_string;
    } item_t;

    typedef struct packed {
        logic [CpW-1:0] code_point;
        logic           last_of_run;
    } result_t;

    // Outcome of one unit against the held surrogate.
    typedef struct packed {
        logic [1:0]       count;
        logic [CpW-1:0]   cp0;
        logic [CpW-1:0]   cp1;
        logic             pend_valid;
        logic [HighW-1:0] pend_bits;
    } dec_t;

endpackage

### hw/rtl/utsd_decode.sv
// Combinational decode of one code unit against the pending high surrogate.
module utsd_decode
    import utsd_pkg::*;
(
    input  item_t            item,
    input  logic             pend_valid,
    input  logic [HighW-1:0] pend_bits,
    output dec_t             dec
);

    logic [UnitW-1:0] u;
    logic             is_pass;
    logic             is_high;
    logic             is_low;
    logic [CpW-1:0]   pair_cp;
    logic [CpW-1:0]   pair_out;
    logic [CpW-1:0]   fresh_cp;
    logic             fresh_emit;

    assign u       = item.code_unit;
    assign is_high = (u[15:10] == HighTag);
    assign is_low  = (u[15:10] == LowTag);
    assign is_pass = (u <= BmpLastLo) || ((u >= BmpFirstHi) && (u < NonChar));

    assign pair_cp  = {1'b0, pend_bits, u[9:0]} + SuppBase;
    assign pair_out = (((pair_cp[15:0] & NonChar) == NonChar) && (pair_cp[20:16] <= MaxPlane))
                      ? ReplCp : pair_cp;

    // Unit handled with nothing pending: a held high unit emits nothing.
    assign fresh_emit = !is_high;
    assign fresh_cp   = is_pass ? {5'd0, u} : ReplCp;

    always_comb
    begin
        dec = '0;
        dec.cp0 = ReplCp;
        dec.cp1 = ReplCp;
        if (item.half_unit)
        begin
            dec.count = 2'd1;
        end
        else
        begin
            if (pend_valid && is_low)
            begin
                dec.count = 2'd1;
                dec.cp0   = pair_out;
            end
            else if (pend_valid)
            begin
                // broken pair: replacement first, then the unit on its own
                dec.count = fresh_emit ? 2'd2 : 2'd1;
                dec.cp1   = fresh_cp;
            end
            else
            begin
                dec.count = fresh_emit ? 2'd1 : 2'd0;
                dec.cp0   = fresh_cp;
            end
            dec.pend_valid = is_high;
            dec.pend_bits  = u[HighW-1:0];
            // flush of a surrogate left pending at end of string
            if (is_high && item.end_of_string)
            begin
                dec.pend_valid = 1'b0;
                dec.pend_bits  = '0;
                dec.count      = dec.count + 2'd1;
            end
        end
    end

endmodule

### hw/rtl/utsd_result_reg.sv
// Output register holding one result request toward the consumer.
module utsd_result_reg
    import utsd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  result_t load_data,
    output logic    can_load,
    output logic    result_valid,
    input  logic    result_ready,
    output result_t result
);

    logic    valid_reg;
    logic    valid_next;
    result_t data_reg;

    assign can_load     = !valid_reg || result_ready;
    assign valid_next   = load || (valid_reg && !result_ready);
    assign result_valid = valid_reg;
    assign result       = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= load_data;
        end
    end

endmodule

### hw/rtl/utsd_top.sv
// Input register, pending surrogate state and result sequencing of the decoder.
module utsd_top
    import utsd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_ready,
    input  item_t   item,
    output logic    result_valid,
    input  logic    result_ready,
    output result_t result
);

    logic             s1_valid_reg;
    logic             s1_valid_next;
    item_t            s1_item_reg;
    logic             sel_reg;
    logic             sel_next;
    logic             pend_valid_reg;
    logic             pend_valid_next;
    logic [HighW-1:0] pend_bits_reg;
    logic [HighW-1:0] pend_bits_next;

    dec_t    dec;
    logic    can_load;
    logic    load_out;
    logic    is_last;
    logic    retire;
    logic    take;
    result_t out_data;

    utsd_decode u_decode (
        .item       (s1_item_reg),
        .pend_valid (pend_valid_reg),
        .pend_bits  (pend_bits_reg),
        .dec        (dec)
    );

    assign is_last  = ({1'b0, sel_reg} == (dec.count - 2'd1));
    assign load_out = s1_valid_reg && (dec.count != 2'd0) && can_load;
    assign retire   = s1_valid_reg && ((dec.count == 2'd0) || (can_load && is_last));
    assign take     = item_valid && item_ready;

    assign item_ready = !s1_valid_reg || retire;

    assign out_data.code_point  = sel_reg ? dec.cp1 : dec.cp0;
    assign out_data.last_of_run = is_last;

    always_comb
    begin
        s1_valid_next   = take || (s1_valid_reg && !retire);
        pend_valid_next = retire ? dec.pend_valid : pend_valid_reg;
        pend_bits_next  = retire ? dec.pend_bits : pend_bits_reg;
        if (retire)
        begin
            sel_next = 1'b0;
        end
        else if (load_out)
        begin
            sel_next = 1'b1;
        end
        else
        begin
            sel_next = sel_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            sel_reg        <= 1'b0;
            pend_valid_reg <= 1'b0;
            pend_bits_reg  <= '0;
        end
        else
        begin
            s1_valid_reg   <= s1_valid_next;
            sel_reg        <= sel_next;
            pend_valid_reg <= pend_valid_next;
            pend_bits_reg  <= pend_bits_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_item_reg <= item;
        end
    end

    utsd_result_reg u_result_reg (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (load_out),
        .load_data    (out_data),
        .can_load     (can_load),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

### hw/rtl/utf16_stream_decoder.sv
//  channel | signals                           | payload
//  item    | item_valid / item_ready          | item_t   (code_unit, half_unit, end_of_string)
//  result  | result_valid / result_ready      | result_t (code_point, last_of_run)
//
//  One unit is taken per cycle while the output register can load; a unit giving two
//  results holds the input register while its second result moves to the output register.
//  The first result passes through the input register, then the output register.
//  A held high surrogate gives no result of its own and does not load the output register.
//  Reset clears the input and output valid flags and the pending surrogate.
//  A stalled consumer fills the output register, then the input register.
module utf16_stream_decoder
    import utsd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_ready,
    input  item_t   item,
    output logic    result_valid,
    input  logic    result_ready,
    output result_t result
);

    utsd_top u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

### tb/utf16_stream_decoder_tb.sv
// Self-checking testbench for the UTF-16 stream decoder: directed table plus random streams.
module utf16_stream_decoder_tb;
    import utsd_pkg::*;

    localparam int IdleLimit  = 1000;
    localparam int TailCycles = 32;
    localparam int RandomReqs = 700;

    typedef struct packed {
        logic [1:0]     n;
        logic [CpW-1:0] cp0;
        logic [CpW-1:0] cp1;
    } cp_run_t;

    typedef struct packed {
        item_t   req;
        logic    typed;
        cp_run_t run;
    } request_row_t;

    logic    clk;
    logic    rst_n;
    logic    item_valid;
    logic    item_ready;
    item_t   item;
    logic    result_valid;
    logic    result_ready;
    result_t result;

    logic [HighW-1:0] held_bits = '0;
    logic             held_valid = 1'b0;
    request_row_t     directed_rows[$];
    request_row_t     row_hints[$];
    item_t            random_reqs[$];
    result_t          expected_cps[$];
    int               errors = 0;
    int               idle_cycles = 0;
    logic             calm;

    utf16_stream_decoder u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    function automatic cp_run_t push_cp(input cp_run_t r, input logic [CpW-1:0] cp);
        if (r.n == 2'd0)
            r.cp0 = cp;
        else
            r.cp1 = cp;
        r.n = r.n + 2'd1;
        return r;
    endfunction

    // Unit handled with nothing held.
    function automatic cp_run_t fresh_unit(input cp_run_t r, input logic [UnitW-1:0] u);
        if (u <= BmpLastLo || (u >= BmpFirstHi && u < NonChar))
            return push_cp(r, {5'd0, u});
        if (u[15:10] == HighTag)
        begin
            held_bits  = u[HighW-1:0];
            held_valid = 1'b1;
            return r;
        end
        return push_cp(r, ReplCp);
    endfunction

    function automatic cp_run_t decode_unit(input item_t it);
        cp_run_t          run;
        logic [HighW-1:0] hb;
        logic [CpW-1:0]   cp;
        run = '0;
        if (it.half_unit)
        begin
            held_bits  = '0;
            held_valid = 1'b0;
            return push_cp(run, ReplCp);
        end
        if (held_valid)
        begin
            hb         = held_bits;
            held_bits  = '0;
            held_valid = 1'b0;
            if (it.code_unit[15:10] == LowTag)
            begin
                cp = {1'b0, hb, it.code_unit[9:0]} + SuppBase;
                if (cp[15:0] >= NonChar)
                    cp = ReplCp;
                run = push_cp(run, cp);
            end
            else
            begin
                run = push_cp(run, ReplCp);
                run = fresh_unit(run, it.code_unit);
            end
        end
        else
            run = fresh_unit(run, it.code_unit);
        if (it.end_of_string && held_valid)
        begin
            held_bits  = '0;
            held_valid = 1'b0;
            run = push_cp(run, ReplCp);
        end
        return run;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(4, 20);
    endfunction

    task automatic add_row(input logic [UnitW-1:0] u, input logic half, input logic eos,
                           input logic typed, input int n,
                           input logic [CpW-1:0] cp0, input logic [CpW-1:0] cp1);
        request_row_t row;
        row.req.code_unit     = u;
        row.req.half_unit     = half;
        row.req.end_of_string = eos;
        row.typed             = typed;
        row.run.n             = n[1:0];
        row.run.cp0           = cp0;
        row.run.cp1           = cp1;
        directed_rows.push_back(row);
    endtask

    task automatic add_random(input logic [UnitW-1:0] u, input logic half, input logic eos);
        item_t it;
        it.code_unit     = u;
        it.half_unit     = half;
        it.end_of_string = eos;
        random_reqs.push_back(it);
    endtask

    // Mostly well-formed text: BMP units and surrogate pairs, with noise mixed in.
    task automatic build_random(input int total);
        int               r;
        logic [HighW-1:0] hb;
        logic [HighW-1:0] lb;
        logic [UnitW-1:0] u;
        while (random_reqs.size() < total)
        begin
            r = $urandom_range(0, 99);
            if (r < 35)
            begin
                if ($urandom_range(0, 1) == 0)
                    u = 16'($urandom_range(0, 16'hD7FF));
                else
                    u = 16'($urandom_range(16'hE000, 16'hFFFD));
                add_random(u, 1'b0, $urandom_range(0, 9) == 0);
            end
            else if (r < 65)
            begin
                hb = 10'($urandom_range(0, 1023));
                lb = 10'($urandom_range(0, 1023));
                if ($urandom_range(0, 7) == 0)
                begin
                    // steer toward a plane-final noncharacter
                    hb[5:0] = 6'h3F;
                    lb      = {9'h1FF, 1'($urandom_range(0, 1))};
                end
                add_random({HighTag, hb}, 1'b0, $urandom_range(0, 19) == 0);
                add_random({LowTag, lb}, 1'b0, $urandom_range(0, 9) == 0);
            end
            else if (r < 80)
                add_random(16'($urandom_range(0, 16'hFFFF)), 1'b0, $urandom_range(0, 7) == 0);
            else if (r < 92)
            begin
                add_random({HighTag, 10'($urandom_range(0, 1023))}, 1'b0, 1'b0);
                case ($urandom_range(0, 2))
                    0: u = 16'($urandom_range(0, 16'hFFFF));
                    1: u = {HighTag, 10'($urandom_range(0, 1023))};
                    default: u = 16'hFFFE | 16'($urandom_range(0, 1));
                endcase
                add_random(u, 1'b0, $urandom_range(0, 4) == 0);
            end
            else
                add_random(16'($urandom_range(0, 16'hFFFF)), 1'b1, $urandom_range(0, 1) == 1);
        end
    endtask

    task automatic send_request(input request_row_t row);
        int gap;
        gap = pick_gap();
        if (gap != 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        row_hints.push_back(row);
        item       <= row.req;
        item_valid <= 1'b1;
        do
            @(posedge clk);
        while (!item_ready);
    endtask

    // Sink side: random stalls, short mostly, now and then long.
    initial
    begin : sink
        int stall_left;
        result_ready <= 1'b0;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (stall_left != 0)
                stall_left--;
            else if (!calm && $urandom_range(0, 9) == 0)
            begin
                result_ready <= 1'b0;
                if ($urandom_range(0, 9) < 8)
                    stall_left = $urandom_range(1, 3);
                else
                    stall_left = $urandom_range(4, 24);
            end
            else
                result_ready <= 1'b1;
        end
    end

    // Prediction on each accepted request, then checking of each accepted result.
    always @(posedge clk)
    begin : scoreboard
        cp_run_t      run;
        request_row_t hint;
        result_t      want;
        if (rst_n && item_valid && item_ready)
        begin
            run  = decode_unit(item);
            hint = row_hints.pop_front();
            if (hint.typed)
                run = hint.run;
            for (int i = 0; i < run.n; i++)
            begin
                want.code_point  = (i == 0) ? run.cp0 : run.cp1;
                want.last_of_run = (i == run.n - 1);
                expected_cps.push_back(want);
            end
        end
        if (rst_n && result_valid && result_ready)
        begin
            if (expected_cps.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, got %h last %b",
                         $time, result.code_point, result.last_of_run);
                errors++;
            end
            else
            begin
                want = expected_cps.pop_front();
                if (result.code_point !== want.code_point)
                begin
                    $display("%0t: code_point expected %h, got %h",
                             $time, want.code_point, result.code_point);
                    errors++;
                end
                if (result.last_of_run !== want.last_of_run)
                begin
                    $display("%0t: last_of_run expected %b, got %b",
                             $time, want.last_of_run, result.last_of_run);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((item_valid && item_ready) || (result_valid && result_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IdleLimit)
            begin
                $display("utf16_stream_decoder_tb failed");
                $finish;
            end
        end
    end

    initial
    begin
        request_row_t row;
        calm        = 1'b0;
        rst_n      <= 1'b0;
        item_valid <= 1'b0;
        item       <= '0;

        //      unit      half  eos  typed n  cp0         cp1
        add_row(16'h0000, 1'b0, 1'b0, 1'b1, 1, 21'h000000, '0);
        add_row(16'hD7FF, 1'b0, 1'b0, 1'b1, 1, 21'h00D7FF, '0);
        add_row(16'hE000, 1'b0, 1'b0, 1'b1, 1, 21'h00E000, '0);
        add_row(16'hFFFD, 1'b0, 1'b0, 1'b1, 1, ReplCp,     '0);
        add_row(16'hFFFE, 1'b0, 1'b0, 1'b1, 1, ReplCp,     '0);
        add_row(16'hFFFF, 1'b0, 1'b0, 1'b1, 1, ReplCp,     '0);
        add_row(16'hDC00, 1'b0, 1'b0, 1'b1, 1, ReplCp,     '0);  // lone low
        add_row(16'hDFFF, 1'b0, 1'b0, 1'b1, 1, ReplCp,     '0);
        add_row(16'hD800, 1'b0, 1'b0, 1'b1, 0, '0,         '0);  // held, no result
        add_row(16'hDC00, 1'b0, 1'b0, 1'b1, 1, SuppBase,   '0);
        add_row(16'hDBFF, 1'b0, 1'b0, 1'b0, 0, '0,         '0);
        add_row(16'hDFFF, 1'b0, 1'b0, 1'b1, 1, ReplCp,     '0);  // U+10FFFF noncharacter
        add_row(16'hDBFF, 1'b0, 1'b0, 1'b0, 0, '0,         '0);
        add_row(16'hDFFD, 1'b0, 1'b0, 1'b1, 1, 21'h10FFFD, '0);
        add_row(16'hD83F, 1'b0, 1'b0, 1'b0, 0, '0,         '0);
        add_row(16'hDFFE, 1'b0, 1'b0, 1'b1, 1, ReplCp,     '0);  // U+1FFFE noncharacter
        add_row(16'hD800, 1'b0, 1'b0, 1'b0, 0, '0,         '0);
        add_row(16'h0041, 1'b0, 1'b0, 1'b1, 2, ReplCp,     21'h000041);
        add_row(16'hD800, 1'b0, 1'b0, 1'b0, 0, '0,         '0);
        add_row(16'hDBFF, 1'b0, 1'b0, 1'b1, 1, ReplCp,     '0);  // high after high
        add_row(16'hDC00, 1'b0, 1'b0, 1'b0, 0, '0,         '0);
        add_row(16'hD800, 1'b0, 1'b1, 1'b1, 1, ReplCp,     '0);  // flushed at end
        add_row(16'h0041, 1'b0, 1'b1, 1'b1, 1, 21'h000041, '0);
        add_row(16'hD800, 1'b0, 1'b0, 1'b0, 0, '0,         '0);
        add_row(16'hFFFF, 1'b1, 1'b1, 1'b1, 1, ReplCp,     '0);  // odd byte eats pending
        add_row(16'hD800, 1'b0, 1'b0, 1'b0, 0, '0,         '0);
        add_row(16'hD800, 1'b0, 1'b1, 1'b1, 2, ReplCp,     ReplCp);
        add_row(16'h0000, 1'b1, 1'b0, 1'b1, 1, ReplCp,     '0);

        build_random(RandomReqs);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
            send_request(directed_rows[i]);

        foreach (random_reqs[i])
        begin
            calm        = (i >= 250 && i < 350);
            row         = '0;
            row.req     = random_reqs[i];
            send_request(row);
        end
        calm = 1'b0;
        item_valid <= 1'b0;

        // let the last accepted request reach the scoreboard first
        @(posedge clk);
        while (expected_cps.size() != 0)
            @(posedge clk);
        repeat (TailCycles) @(posedge clk);

        if (errors == 0)
            $display("utf16_stream_decoder_tb passed");
        else
            $display("utf16_stream_decoder_tb failed");
        $finish;
    end

endmodule
